// ===== rtl/periodic_task_dispatcher_unit_assert.svh =====
// Assertion macros for the dispatcher modules; only ptd_scan uses them.
// Needs clk and rst in the scope of each use; no other dependencies.
`ifndef PERIODIC_TASK_DISPATCHER_UNIT_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, inactive while reset is high.
`define PTD_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive while reset is high.
`define PTD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ptd_pkg.sv =====
// Types, operation codes and helpers for the periodic task dispatcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package ptd_pkg;

  localparam logic [1:0] KIND_TICK      = 2'd0;
  localparam logic [1:0] KIND_CREATE    = 2'd1;
  localparam logic [1:0] KIND_SET_STATE = 2'd2;
  localparam logic [1:0] KIND_DELETE    = 2'd3;

  localparam int ID_W     = 3;
  localparam int PERIOD_W = 16;
  localparam int DELAY_W  = 8;

  // One slot entry as kept in the slot memory.
  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] countdown;
  } entry_t;

  // Memory port strobes from the scanner.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // One result word handed to the output register.
  typedef struct packed {
    logic            vld;
    logic [ID_W-1:0] id;
    logic            last;
  } push_t;

  // Countdown reload on release; a zero period behaves as a period of one.
  function automatic logic [PERIOD_W-1:0] reload_value(input logic [PERIOD_W-1:0] per);
    logic [PERIOD_W-1:0] res;
    if (per == '0) begin
      res = '0;
    end else begin
      res = per - 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ptd_slot_mem.sv =====
// Slot memory: period and countdown of every task slot.
// Depends on ptd_pkg (entry_t). One write port, one registered read port.
`default_nettype none

module ptd_slot_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire logic            clk,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output ptd_pkg::entry_t      rd_data,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire ptd_pkg::entry_t wr_data
);
  import ptd_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ptd_out_reg.sv =====
// Output register of the result channel.
// Depends on ptd_pkg (push_t); reports when it can take a new word.
`default_nettype none

module ptd_out_reg (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ptd_pkg::push_t           push,
  output logic                          free,
  output logic                          due_valid,
  input  wire logic                     due_ready,
  output logic [ptd_pkg::ID_W-1:0]      due_task,
  output logic                          last
);
  import ptd_pkg::*;

  assign free = !due_valid || due_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      due_valid <= 1'b0;
    end else if (push.vld) begin
      due_valid <= 1'b1;
    end else if (due_ready) begin
      due_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      due_task <= push.id;
      last     <= push.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ptd_scan.sv =====
// Command decode, slot flags and the tick scan over the slot memory.
// Depends on ptd_pkg and the assertion macro header.
`default_nettype none
`include "periodic_task_dispatcher_unit_assert.svh"

module ptd_scan #(
  parameter int NUM_TASKS = 8,
  parameter int IDX_W     = 3,
  parameter int CNT_W     = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire logic [1:0]                    kind,
  input  wire logic [ptd_pkg::ID_W-1:0]      task_id,
  input  wire logic [ptd_pkg::PERIOD_W-1:0]  period,
  input  wire logic [ptd_pkg::DELAY_W-1:0]   first_delay,
  input  wire logic                          ready_req,
  input  wire logic                          out_free,
  output ptd_pkg::push_t                     push,
  output ptd_pkg::mem_ctl_t                  mem_ctl,
  output logic [IDX_W-1:0]                   rd_addr,
  input  wire ptd_pkg::entry_t               rd_data,
  output logic [IDX_W-1:0]                   wr_addr,
  output ptd_pkg::entry_t                    wr_data
);
  import ptd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]           state;
  logic [NUM_TASKS-1:0] slot_valid;
  logic [NUM_TASKS-1:0] slot_ready;
  logic [CNT_W-1:0]     rd_cnt;
  logic                 b_vld;
  logic [IDX_W-1:0]     b_idx;
  logic                 pend_vld;
  logic [IDX_W-1:0]     pend_id;

  logic             accept;
  logic             cmd_hit;
  logic [IDX_W-1:0] cmd_idx;
  logic             b_vr;
  logic             b_rel;
  logic             stall;
  logic             a_more;

  always_comb begin
    cmd_ready = (state == ST_IDLE);
    accept    = cmd_valid && cmd_ready;
    cmd_idx   = IDX_W'(task_id);
    cmd_hit   = accept && (kind != KIND_TICK) && (32'(task_id) < NUM_TASKS);
    b_vr      = b_vld && slot_valid[b_idx] && slot_ready[b_idx];
    b_rel     = b_vr && (rd_data.countdown == '0);
    stall     = b_rel && pend_vld && !out_free;
    a_more    = rd_cnt < CNT_W'(NUM_TASKS);

    mem_ctl.rd_en = (state == ST_SCAN) && !stall && a_more;
    rd_addr       = rd_cnt[IDX_W-1:0];

    if (state == ST_IDLE) begin
      mem_ctl.wr_en     = cmd_hit && (kind == KIND_CREATE);
      wr_addr           = cmd_idx;
      wr_data.period    = period;
      wr_data.countdown = PERIOD_W'(first_delay);
    end else begin
      mem_ctl.wr_en     = (state == ST_SCAN) && b_vr && !stall;
      wr_addr           = b_idx;
      wr_data.period    = rd_data.period;
      wr_data.countdown = b_rel ? reload_value(rd_data.period)
                                : rd_data.countdown - 1'b1;
    end

    push.vld  = 1'b0;
    push.id   = ID_W'(pend_id);
    push.last = 1'b0;
    if (state == ST_SCAN) begin
      push.vld = b_rel && pend_vld && !stall;
    end else if (state == ST_FLUSH) begin
      push.vld  = pend_vld && out_free;
      push.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_ready <= '0;
    end else if (cmd_hit) begin
      unique case (kind)
        KIND_CREATE: begin
          slot_valid[cmd_idx] <= 1'b1;
          slot_ready[cmd_idx] <= 1'b1;
        end
        KIND_SET_STATE: slot_ready[cmd_idx] <= ready_req;
        KIND_DELETE:    slot_valid[cmd_idx] <= 1'b0;
        KIND_TICK: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_cnt   <= '0;
      b_vld    <= 1'b0;
      pend_vld <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && (kind == KIND_TICK)) begin
            state  <= ST_SCAN;
            rd_cnt <= '0;
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            b_vld <= mem_ctl.rd_en;
            if (mem_ctl.rd_en) begin
              rd_cnt <= CNT_W'(rd_cnt + 1'b1);
            end
            if (b_rel) begin
              pend_vld <= 1'b1;
            end
          end
          if (!a_more && !b_vld) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!pend_vld) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pend_vld <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) && !stall) begin
      b_idx <= rd_cnt[IDX_W-1:0];
      if (b_rel) begin
        pend_id <= b_idx;
      end
    end
  end

  `PTD_ASSERT_IMPLIES(a_idle_empty, state == ST_IDLE, !b_vld && !pend_vld,
    "scan pipeline not empty while idle")
  `PTD_ASSERT_IMPLIES(a_rw_apart, mem_ctl.wr_en && mem_ctl.rd_en, wr_addr != rd_addr,
    "write-back and read hit the same slot")
  `PTD_ASSERT_NEXT(a_stall_hold, (state == ST_SCAN) && stall,
    b_vld && $stable(b_idx) && $stable(rd_cnt), "scan moved during a stall")
  `PTD_ASSERT_IMPLIES(a_push_room, push.vld, out_free,
    "result pushed into a full output register")

endmodule

`default_nettype wire

// ===== rtl/periodic_task_dispatcher_unit.sv =====
// Periodic task dispatcher, top level.
// Depends on ptd_pkg, ptd_slot_mem, ptd_scan and ptd_out_reg.
//
//   channel   handshake              payload
//   -------   --------------------   -------------------------------------------
//   cmd       cmd_valid / cmd_ready  kind, task_id, period, first_delay, ready_req
//   due       due_valid / due_ready  due_task, last
//
// cmd_ready stays high for create, set state and delete.
// A tick holds cmd_ready low while the scan of the slot memory runs, one slot
//   read per cycle while the scan is not stalled, each update written back from
//   the registered read data; only then can the next tick be taken.
// Reset clears every slot's valid and ready mark at once; no clearing pass.
// A stalled due channel holds the scan only when a new release is found while
//   one release waits in the scan and another in the output register; the
//   closing word of a tick also waits for room. cmd_ready is low for the whole tick.
`default_nettype none

module periodic_task_dispatcher_unit #(
  parameter int NUM_TASKS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire logic [1:0]                    kind,
  input  wire logic [ptd_pkg::ID_W-1:0]      task_id,
  input  wire logic [ptd_pkg::PERIOD_W-1:0]  period,
  input  wire logic [ptd_pkg::DELAY_W-1:0]   first_delay,
  input  wire logic                          ready_req,
  output logic                               due_valid,
  input  wire logic                          due_ready,
  output logic [ptd_pkg::ID_W-1:0]           due_task,
  output logic                               last
);
  import ptd_pkg::*;

  // Slot index and scan counter widths; the counter also holds NUM_TASKS.
  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W = $clog2(NUM_TASKS + 1);

  mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  entry_t           rd_data;
  entry_t           wr_data;
  push_t            push;
  logic             out_free;

  // Period and countdown of every slot live here.
  ptd_slot_mem #(
    .DEPTH (NUM_TASKS),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (mem_ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Decode commands, hold the flags and walk the slots on a tick.
  ptd_scan #(
    .NUM_TASKS (NUM_TASKS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .kind        (kind),
    .task_id     (task_id),
    .period      (period),
    .first_delay (first_delay),
    .ready_req   (ready_req),
    .out_free    (out_free),
    .push        (push),
    .mem_ctl     (mem_ctl),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  // Hold one released id until the consumer takes the word.
  ptd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .free      (out_free),
    .due_valid (due_valid),
    .due_ready (due_ready),
    .due_task  (due_task),
    .last      (last)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for periodic_task_dispatcher_unit: a directed table, then random words.
// Predicts released task ids with a private slot table; needs ptd_pkg and the dispatcher RTL.

module testbench;

  import ptd_pkg::*;

  localparam int N_SLOTS      = 8;
  localparam int N_ROWS       = 23;
  localparam int N_RANDOM     = 187;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 4 * (N_SLOTS + 3);
  localparam int LIMIT_CYCLES = 200000;
  localparam int SHOW_MAX     = 10;

  // One command word of the directed table. When 'typed' is set, 'want' lists
  // the slots released by a tick and replaces the predicted set.
  typedef struct packed {
    logic [1:0]          kind;
    logic [ID_W-1:0]     id;
    logic [PERIOD_W-1:0] per;
    logic [DELAY_W-1:0]  dly;
    logic                rdy;
    logic                typed;
    logic [N_SLOTS-1:0]  want;
  } cmd_row_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            last;
  } due_word_t;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                cmd_valid   = 1'b0;
  logic [1:0]          kind        = KIND_TICK;
  logic [ID_W-1:0]     task_id     = '0;
  logic [PERIOD_W-1:0] period      = '0;
  logic [DELAY_W-1:0]  first_delay = '0;
  logic                ready_req   = 1'b0;
  logic                due_ready   = 1'b0;
  logic                cmd_ready;
  logic                due_valid;
  logic [ID_W-1:0]     due_task;
  logic                last;

  // Private copy of the slot table.
  logic                slot_live  [N_SLOTS];
  logic                slot_armed [N_SLOTS];
  logic [PERIOD_W-1:0] slot_per   [N_SLOTS];
  logic [PERIOD_W-1:0] slot_count [N_SLOTS];

  due_word_t pending_due[$];
  cmd_row_t  plan [N_ROWS];
  int        bad_words = 0;
  int        cycles    = 0;
  bit        hold_req  = 1'b0;

  periodic_task_dispatcher_unit #(
    .NUM_TASKS(N_SLOTS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .kind       (kind),
    .task_id    (task_id),
    .period     (period),
    .first_delay(first_delay),
    .ready_req  (ready_req),
    .due_valid  (due_valid),
    .due_ready  (due_ready),
    .due_task   (due_task),
    .last       (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one accepted word to the private table and return the set of slots
  // released by it, one bit per slot. Only ticks release anything.
  function automatic logic [N_SLOTS-1:0] dispatch_word(input cmd_row_t w);
    logic [N_SLOTS-1:0] fired;
    int s;
    fired = '0;
    case (w.kind)
      KIND_TICK: begin
        // Scan in slot order; skip slots that are deleted or suspended.
        for (s = 0; s < N_SLOTS; s++) begin
          if (slot_live[s] && slot_armed[s]) begin
            if (slot_count[s] == '0) begin
              fired[s] = 1'b1;
              // A zero period reloads exactly as a period of one does.
              slot_count[s] = (slot_per[s] == '0) ? '0 : slot_per[s] - 1'b1;
            end else begin
              slot_count[s] = slot_count[s] - 1'b1;
            end
          end
        end
      end
      // Every 3-bit id names a slot, so no word is dropped as out of range.
      KIND_CREATE: begin
        slot_live[w.id]  = 1'b1;
        slot_armed[w.id] = 1'b1;
        slot_per[w.id]   = w.per;
        slot_count[w.id] = {{(PERIOD_W - DELAY_W){1'b0}}, w.dly};
      end
      KIND_SET_STATE: begin
        // Written even on a deleted slot; a later create re-arms it anyway.
        slot_armed[w.id] = w.rdy;
      end
      default: begin
        // Delete drops the valid mark only; period and countdown stay.
        slot_live[w.id] = 1'b0;
      end
    endcase
    return fired;
  endfunction

  // Turn a release set into due words, lowest slot first, last on the highest.
  task automatic queue_releases(input logic [N_SLOTS-1:0] fired);
    int s;
    int top;
    due_word_t dw;
    top = -1;
    for (s = 0; s < N_SLOTS; s++) begin
      if (fired[s]) begin
        top = s;
      end
    end
    for (s = 0; s < N_SLOTS; s++) begin
      if (fired[s]) begin
        dw.id   = s[ID_W-1:0];
        dw.last = (s == top);
        pending_due.push_back(dw);
      end
    end
  endtask

  // Offer one command word and hold it until the handshake. Valid is left high
  // so that a following word in the same burst goes out without a gap.
  task automatic offer_word(input cmd_row_t w);
    logic               took;
    logic [N_SLOTS-1:0] fired;
    cmd_valid   <= 1'b1;
    kind        <= w.kind;
    task_id     <= w.id;
    period      <= w.per;
    first_delay <= w.dly;
    ready_req   <= w.rdy;
    took = 1'b0;
    // Inputs move only at rising edges, so the level at the falling edge is
    // what the next rising edge sees.
    while (!took) begin
      @(negedge clk);
      took = cmd_ready;
      @(posedge clk);
    end
    fired = dispatch_word(w);
    queue_releases(w.typed ? w.want : fired);
  endtask

  // Random command word: mostly ticks and creates with short periods and
  // delays so that releases keep coming, with full-range values now and then.
  function automatic cmd_row_t random_word();
    cmd_row_t w;
    int pick;
    w.id    = ID_W'($urandom_range(0, N_SLOTS - 1));
    w.per   = PERIOD_W'($urandom());
    w.dly   = DELAY_W'($urandom());
    w.rdy   = ($urandom_range(0, 9) < 7);
    w.typed = 1'b0;
    w.want  = '0;
    pick    = $urandom_range(0, 99);
    if (pick < 45) begin
      w.kind = KIND_TICK;
    end else if (pick < 72) begin
      w.kind = KIND_CREATE;
      pick   = $urandom_range(0, 9);
      if (pick < 6) begin
        w.per = PERIOD_W'($urandom_range(0, 4));
      end else if (pick < 8) begin
        w.per = PERIOD_W'($urandom_range(5, 40));
      end else if (pick == 9) begin
        w.per = '1;
      end
      if ($urandom_range(0, 4) != 0) begin
        w.dly = DELAY_W'($urandom_range(0, 4));
      end
    end else if (pick < 88) begin
      w.kind = KIND_SET_STATE;
    end else begin
      w.kind = KIND_DELETE;
    end
    return w;
  endfunction

  // Command side: reset, the directed table, then random words, all in bursts.
  initial begin : cmd_source
    cmd_row_t w;
    int burst_left;
    int gap;
    int n;

    plan[0]  = '{KIND_TICK,      3'd0, 16'd0,     8'd0,   1'b0, 1'b1, 8'h00};
    plan[1]  = '{KIND_CREATE,    3'd0, 16'd0,     8'd0,   1'b0, 1'b0, 8'h00};
    plan[2]  = '{KIND_CREATE,    3'd7, 16'hFFFF,  8'hFF,  1'b0, 1'b0, 8'h00};
    plan[3]  = '{KIND_CREATE,    3'd3, 16'd3,     8'd1,   1'b0, 1'b0, 8'h00};
    plan[4]  = '{KIND_TICK,      3'd0, 16'd0,     8'd0,   1'b0, 1'b1, 8'h01};
    plan[5]  = '{KIND_TICK,      3'd0, 16'd0,     8'd0,   1'b0, 1'b1, 8'h09};
    plan[6]  = '{KIND_SET_STATE, 3'd0, 16'd0,     8'd0,   1'b0, 1'b0, 8'h00};
    plan[7]  = '{KIND_TICK,      3'd0, 16'd0,     8'd0,   1'b0, 1'b1, 8'h00};
    plan[8]  = '{KIND_SET_STATE, 3'd5, 16'd0,     8'd0,   1'b1, 1'b0, 8'h00};
    plan[9]  = '{KIND_TICK,      3'd0, 16'd0,     8'd0,   1'b0, 1'b0, 8'h00};
    plan[10] = '{KIND_TICK,      3'd0, 16'd0,     8'd0,   1'b0, 1'b1, 8'h08};
    plan[11] = '{KIND_DELETE,    3'd3, 16'd0,     8'd0,   1'b0, 1'b0, 8'h00};
    plan[12] = '{KIND_SET_STATE, 3'd0, 16'd0,     8'd0,   1'b1, 1'b0, 8'h00};
    plan[13] = '{KIND_TICK,      3'd0, 16'd0,     8'd0,   1'b0, 1'b1, 8'h01};
    plan[14] = '{KIND_CREATE,    3'd1, 16'd1,     8'd0,   1'b0, 1'b0, 8'h00};
    plan[15] = '{KIND_CREATE,    3'd2, 16'd1,     8'd0,   1'b0, 1'b0, 8'h00};
    plan[16] = '{KIND_CREATE,    3'd3, 16'd1,     8'd0,   1'b0, 1'b0, 8'h00};
    plan[17] = '{KIND_CREATE,    3'd4, 16'd1,     8'd0,   1'b0, 1'b0, 8'h00};
    plan[18] = '{KIND_CREATE,    3'd5, 16'd1,     8'd0,   1'b0, 1'b0, 8'h00};
    plan[19] = '{KIND_CREATE,    3'd6, 16'd1,     8'd0,   1'b0, 1'b0, 8'h00};
    plan[20] = '{KIND_CREATE,    3'd7, 16'd1,     8'd0,   1'b0, 1'b0, 8'h00};
    plan[21] = '{KIND_TICK,      3'd0, 16'd0,     8'd0,   1'b0, 1'b1, 8'hFF};
    plan[22] = '{KIND_TICK,      3'd0, 16'd0,     8'd0,   1'b0, 1'b1, 8'hFF};

    for (n = 0; n < N_SLOTS; n++) begin
      slot_live[n]  = 1'b0;
      slot_armed[n] = 1'b0;
      slot_per[n]   = '0;
      slot_count[n] = '0;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    burst_left = $urandom_range(1, 12);
    for (n = 0; n < N_ROWS + N_RANDOM; n++) begin
      if (n == N_ROWS) begin
        // Every slot now releases on each tick: stall the due side here so
        // the block backs up onto the command side.
        hold_req = 1'b1;
      end
      w = (n < N_ROWS) ? plan[n] : random_word();
      offer_word(w);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          cmd_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    cmd_valid <= 1'b0;

    // Drain: wait for every predicted due word, then watch for strays.
    while (pending_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_words == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Due side: one long hold when asked, otherwise stretches of always-ready,
  // coin-flip and mostly-stalled acceptance.
  initial begin : due_sink
    int seg;
    int mode;
    bit held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        due_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        seg  = $urandom_range(1, 40);
        mode = $urandom_range(0, 2);
        repeat (seg) begin
          case (mode)
            0:       due_ready <= 1'b1;
            1:       due_ready <= $urandom_range(0, 1);
            default: due_ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Check each accepted due word against the oldest prediction. Sample at the
  // falling edge, where inputs and outputs are settled for the coming edge.
  always @(negedge clk) begin : due_check
    due_word_t wanted;
    if (!rst && due_valid && due_ready) begin
      if (pending_due.size() == 0) begin
        bad_words++;
        if (bad_words <= SHOW_MAX) begin
          $display("unexpected due word: task %0d last %0b", due_task, last);
        end
      end else begin
        wanted = pending_due.pop_front();
        if (due_task !== wanted.id || last !== wanted.last) begin
          bad_words++;
          if (bad_words <= SHOW_MAX) begin
            $display("due word mismatch: expected task %0d last %0b, got task %0d last %0b",
                     wanted.id, wanted.last, due_task, last);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake or a missing due word ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("testbench failed");
      $finish;
    end
  end

endmodule
